>>> sv/lhp_pkg.sv
package lhp_pkg;

  // Default histogram range in whole milliseconds.
  localparam int unsigned MAX_LATENCY_MS_DEF = 1000;

  // Field widths fixed by the interface.
  localparam int unsigned ACT_W = 2;
  localparam int unsigned LAT_W = 32;
  localparam int unsigned Q_W   = 17;
  localparam int unsigned PCT_W = 10;
  localparam int unsigned TOT_W = 42;
  localparam int unsigned BKT_W = 32;

  // Quantile of one in unsigned Q1.16.
  localparam logic [Q_W-1:0] Q16_ONE = 17'h10000;

  // The rank product is formed from two partial products of the total.
  localparam int unsigned TOT_LO_W = 21;
  localparam int unsigned TOT_HI_W = TOT_W - TOT_LO_W;

  // Request codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_OBSERVE     = 2'd0,
    ACT_QUERY       = 2'd1,
    ACT_QUERY_CLEAR = 2'd2
  } lhp_action_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [LAT_W-1:0] latency_ms;
    logic [Q_W-1:0]          quantile_q16;
  } lhp_in_t;

  typedef struct packed {
    logic [PCT_W-1:0] percentile_ms;
    logic [TOT_W-1:0] total_count;
  } lhp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic obs_rd;
    logic obs_wr;
    logic q_cap;
    logic pct_zero;
    logic mul_lo;
    logic mul_hi;
    logic rank_calc;
    logic walk_rd;
    logic out_load;
    logic addr_zero;
  } lhp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_addr;
    logic total_zero;
    logic walk_done;
    logic out_free;
  } lhp_stat_t;

endpackage

>>> sv/lhp_ctrl.sv
module lhp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  lhp_pkg::lhp_stat_t stat,
  output lhp_pkg::lhp_cmd_t  cmd
);
  import lhp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_OBS_WR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RANK,
    ST_WALK,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_pend_r, clr_pend_nxt;

  // Next state and the commands issued in each state.
  always_comb begin
    state_nxt    = state_r;
    clr_pend_nxt = clr_pend_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.last_addr) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            ACT_OBSERVE: begin
              cmd.obs_rd = 1'b1;
              state_nxt  = ST_OBS_WR;
            end
            ACT_QUERY, ACT_QUERY_CLEAR: begin
              cmd.q_cap    = 1'b1;
              clr_pend_nxt = (in_action == ACT_QUERY_CLEAR);
              if (stat.total_zero) begin
                cmd.pct_zero = 1'b1;
                state_nxt    = ST_RESULT;
              end else begin
                state_nxt = ST_MUL_LO;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_OBS_WR: begin
        cmd.obs_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_RANK;
      end
      ST_RANK: begin
        cmd.rank_calc = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (stat.walk_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (clr_pend_r) begin
            cmd.addr_zero = 1'b1;
            state_nxt     = ST_CLR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts with a sweep that zeroes the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule

>>> sv/lhp_dp.sv
module lhp_dp #(
  parameter int unsigned MAX_LATENCY_MS = lhp_pkg::MAX_LATENCY_MS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lhp_pkg::lhp_in_t   in_data,
  input  lhp_pkg::lhp_cmd_t  cmd,
  output lhp_pkg::lhp_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output lhp_pkg::lhp_out_t  out_data
);
  import lhp_pkg::*;

  localparam int unsigned NUM_BKT = MAX_LATENCY_MS + 1;
  localparam int unsigned IDX_W   = (NUM_BKT > 1) ? $clog2(NUM_BKT) : 1;
  localparam int unsigned SUM_W   = BKT_W + IDX_W;
  localparam int unsigned CMP_W   = (SUM_W > TOT_W) ? SUM_W : TOT_W;
  localparam int unsigned PP_W    = Q_W + TOT_LO_W;
  localparam int unsigned PROD_W  = Q_W + TOT_W + 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LATENCY_MS);
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [BKT_W-1:0] BKT_MAX = '1;

  logic [BKT_W-1:0] mem [NUM_BKT];
  logic [BKT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr, wr_addr, clamp_idx;
  logic [BKT_W-1:0] wr_data;
  logic             wr_en, bkt_full;

  logic [IDX_W-1:0] addr_r, obs_addr_r, data_idx_r, pct_r;
  logic             data_vld_r;
  logic [TOT_W-1:0] total_r, rank_r;
  logic [Q_W-1:0]   q_r;
  logic [PP_W-1:0]  prod_lo_r, prod_hi_r;
  logic [CMP_W-1:0] cum_r, cum_sum;
  logic [PROD_W-1:0] prod_sum;
  logic [TOT_W-1:0] rank_raw;
  logic             hit;
  logic             out_valid_r;
  lhp_out_t         out_data_r;

  // Clamp the observed latency into the bucket range.
  always_comb begin
    if (in_data.latency_ms[LAT_W-1]) begin
      clamp_idx = '0;
    end else if (in_data.latency_ms > LAT_W'(MAX_LATENCY_MS)) begin
      clamp_idx = IDX_MAX;
    end else begin
      clamp_idx = in_data.latency_ms[IDX_W-1:0];
    end
  end

  // Bucket store: one write port, one registered read port.
  assign bkt_full = (rd_data_r == BKT_MAX);
  assign rd_addr  = cmd.obs_rd ? clamp_idx : addr_r;
  assign wr_addr  = cmd.clr_wr ? addr_r : obs_addr_r;
  assign wr_data  = cmd.clr_wr ? '0 : rd_data_r + 1'b1;
  assign wr_en    = cmd.clr_wr | (cmd.obs_wr & ~bkt_full);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Rank = max(1, ceil(q * total / 65536)) from two registered partial products.
  assign prod_sum = (PROD_W'(prod_hi_r) << TOT_LO_W) + PROD_W'(prod_lo_r)
                  + PROD_W'(Q16_ONE - 1'b1);
  assign rank_raw = prod_sum[16 +: TOT_W];

  // Running sum of the walk and the test against the rank.
  assign cum_sum = cum_r + CMP_W'(rd_data_r);
  assign hit     = (cum_sum >= CMP_W'(rank_r));

  // Address counter, walk bookkeeping and the running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      data_vld_r <= 1'b0;
      total_r    <= '0;
    end else begin
      data_vld_r <= cmd.walk_rd;
      if (cmd.clr_wr) begin
        total_r <= '0;
        if (addr_r != IDX_MAX) begin
          addr_r <= addr_r + 1'b1;
        end
      end else if (cmd.rank_calc || cmd.addr_zero) begin
        addr_r <= '0;
      end else if (cmd.walk_rd && addr_r != IDX_MAX) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.obs_wr && !bkt_full && total_r != TOT_MAX) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  // Operand, product and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.obs_rd) begin
      obs_addr_r <= clamp_idx;
    end
    if (cmd.q_cap) begin
      q_r <= (in_data.quantile_q16 > Q16_ONE) ? Q16_ONE : in_data.quantile_q16;
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= PP_W'(q_r * total_r[TOT_LO_W-1:0]);
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= PP_W'(q_r * total_r[TOT_W-1:TOT_LO_W]);
    end
    if (cmd.rank_calc) begin
      rank_r <= (rank_raw == '0) ? TOT_W'(1) : rank_raw;
      cum_r  <= '0;
    end else if (cmd.walk_rd && data_vld_r) begin
      cum_r <= cum_sum;
    end
    if (cmd.walk_rd) begin
      data_idx_r <= addr_r;
    end
    if (cmd.pct_zero) begin
      pct_r <= '0;
    end else if (cmd.walk_rd && stat.walk_done) begin
      pct_r <= data_idx_r;
    end
  end

  // Output register: a finished result waits here for the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.percentile_ms <= PCT_W'(pct_r);
      out_data_r.total_count   <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status back to the controller.
  assign stat.last_addr  = (addr_r == IDX_MAX);
  assign stat.total_zero = (total_r == '0);
  assign stat.walk_done  = data_vld_r & (hit | (data_idx_r == IDX_MAX));
  assign stat.out_free   = ~out_valid_r | out_ready;

endmodule

>>> sv/latency_histogram_percentile_top.sv
// Latency histogram with one 32-bit saturating counter per millisecond from 0 to
// MAX_LATENCY_MS, held in a single-port-write, registered-read memory, plus a 42-bit
// total. An observe request reads the bucket, then increments it and writes it back.
// A query forms the rank from two 17x21 partial products, one per cycle, then walks
// the buckets one memory read per cycle, ending at the bucket where the running sum
// reaches the rank, and hands the result to the output register once that is free;
// an empty histogram skips the rank and the walk and answers zero. A query-and-clear
// is followed by a sweep that zeroes the memory, and the same sweep runs after reset;
// no request is accepted during a sweep. One request is worked on at a time, and a
// result may wait in the output register while the next is taken.
module latency_histogram_percentile_top #(
  parameter int unsigned MAX_LATENCY_MS = lhp_pkg::MAX_LATENCY_MS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lhp_pkg::lhp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lhp_pkg::lhp_out_t out_data
);
  import lhp_pkg::*;

  lhp_cmd_t  cmd;
  lhp_stat_t stat;

  // Sequencer.
  lhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Bucket store, rank arithmetic and output register.
  lhp_dp #(
    .MAX_LATENCY_MS (MAX_LATENCY_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while the output register was still occupied");

  // A write-back of an observe always follows its read.
  a_obs_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.obs_wr |-> $past(cmd.obs_rd))
    else $error("observe write-back without a preceding read");

  // No request is taken while the store is being swept or walked.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_wr || cmd.walk_rd) |-> !in_ready)
    else $error("request accepted during a sweep or walk");

endmodule
